>>> hdl/protobuf_field_locator_defines.svh
// assertion macros used by the protobuf field locator top level
`ifndef PROTOBUF_FIELD_LOCATOR_DEFINES_SVH
`define PROTOBUF_FIELD_LOCATOR_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PBFL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("protobuf_field_locator: assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define PBFL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("protobuf_field_locator: assertion failed");

`endif

>>> hdl/pbfl_pkg.sv
// types, codes and constants of the protobuf field locator
`timescale 1ns / 1ps
package pbfl_pkg;

  localparam int unsigned MaxMessageBytesDefault = 65536;
  localparam int unsigned TargetWidth            = 29;
  localparam logic [TargetWidth-1:0] TargetReset = 29'd1;

  localparam int unsigned OffsetWidth = 16;
  localparam int unsigned LengthWidth = 17;

  // scan phase codes
  localparam logic [2:0] PhTag     = 3'd0;
  localparam logic [2:0] PhVarskip = 3'd1;
  localparam logic [2:0] PhLen     = 3'd2;
  localparam logic [2:0] PhNamelen = 3'd3;
  localparam logic [2:0] PhSkip    = 3'd4;
  localparam logic [2:0] PhName    = 3'd5;
  localparam logic [2:0] PhFound   = 3'd6;
  localparam logic [2:0] PhErr     = 3'd7;

  // wire types
  localparam logic [2:0] WtVarint  = 3'd0;
  localparam logic [2:0] WtFixed64 = 3'd1;
  localparam logic [2:0] WtLenDlm  = 3'd2;
  localparam logic [2:0] WtFixed32 = 3'd5;

  localparam logic [3:0] VarintMaxBytes = 4'd10;

  // result status codes
  localparam logic [1:0] StatusFound     = 2'd0;
  localparam logic [1:0] StatusAbsent    = 2'd1;
  localparam logic [1:0] StatusMalformed = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [OffsetWidth-1:0] name_offset;
    logic [LengthWidth-1:0] name_length;
  } out_item_t;

endpackage

>>> hdl/pbfl_scan.sv
// byte-wise wire-format scanner: parser state and per-byte next-state logic
`timescale 1ns / 1ps
module pbfl_scan #(
  parameter int unsigned MaxMessageBytes = pbfl_pkg::MaxMessageBytesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  pbfl_pkg::in_item_t                  item_i,
  input  logic [pbfl_pkg::TargetWidth-1:0]    target_i,
  output pbfl_pkg::out_item_t                 result_o
);
  import pbfl_pkg::*;

  localparam int unsigned PosWidth = $clog2(MaxMessageBytes + 1);
  localparam logic [PosWidth-1:0] PosMax = PosWidth'(MaxMessageBytes);

  logic [2:0]             phase_q, phase_d;
  logic [63:0]            acc_q, acc_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [PosWidth-1:0]    skip_q, skip_d;
  logic [PosWidth-1:0]    pos_q, pos_d;
  logic [OffsetWidth-1:0] off_q, off_d;
  logic [LengthWidth-1:0] len_q, len_d;

  logic [6:0]             sh_full;
  logic [63:0]            acc_new;
  logic [2:0]             wt;
  logic [60:0]            fnum;
  logic                   len_big;
  logic [PosWidth-1:0]    pos_after;
  logic [PosWidth-1:0]    skip_dec;
  logic [3:0]             cnt_inc;

  always_comb begin
    sh_full   = 7'(cnt_q) * 7'd7;
    acc_new   = acc_q | (64'(item_i.data_byte[6:0]) << sh_full[5:0]);
    wt        = acc_new[2:0];
    fnum      = acc_new[63:3];
    len_big   = acc_new > 64'(MaxMessageBytes);
    pos_after = pos_q + PosWidth'(1);
    skip_dec  = (skip_q == '0) ? skip_q : skip_q - PosWidth'(1);
    cnt_inc   = cnt_q + 4'd1;

    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    pos_d   = pos_q;
    off_d   = off_q;
    len_d   = len_q;

    if (phase_q != PhFound && phase_q != PhErr) begin
      if (pos_q >= PosMax) begin
        phase_d = PhErr;
      end else begin
        pos_d = pos_after;
        if (phase_q == PhSkip || phase_q == PhName) begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = (phase_q == PhName) ? PhFound : PhTag;
          end
        end else if (item_i.data_byte[7]) begin
          acc_d = acc_new;
          cnt_d = cnt_inc;
          if (cnt_inc >= VarintMaxBytes) begin
            phase_d = PhErr;
          end
        end else begin
          acc_d = '0;
          cnt_d = '0;
          case (phase_q)
            PhTag: begin
              if (wt == WtLenDlm && fnum == 61'(target_i)) begin
                phase_d = PhNamelen;
              end else if (wt == WtVarint) begin
                phase_d = PhVarskip;
              end else if (wt == WtFixed64) begin
                skip_d  = PosWidth'(8);
                phase_d = PhSkip;
              end else if (wt == WtLenDlm) begin
                phase_d = PhLen;
              end else if (wt == WtFixed32) begin
                skip_d  = PosWidth'(4);
                phase_d = PhSkip;
              end else begin
                phase_d = PhErr;
              end
            end
            PhVarskip: begin
              phase_d = PhTag;
            end
            PhLen: begin
              if (len_big) begin
                phase_d = PhErr;
              end else if (acc_new == '0) begin
                phase_d = PhTag;
              end else begin
                skip_d  = acc_new[PosWidth-1:0];
                phase_d = PhSkip;
              end
            end
            PhNamelen: begin
              if (len_big) begin
                phase_d = PhErr;
              end else begin
                off_d = OffsetWidth'(pos_after);
                len_d = LengthWidth'(acc_new[PosWidth-1:0]);
                if (acc_new == '0) begin
                  phase_d = PhFound;
                end else begin
                  skip_d  = acc_new[PosWidth-1:0];
                  phase_d = PhName;
                end
              end
            end
            default: begin
              phase_d = PhErr;
            end
          endcase
        end
      end
    end

    // verdict seen after this byte
    result_o.name_offset = '0;
    result_o.name_length = '0;
    if (phase_d == PhFound) begin
      result_o.status      = StatusFound;
      result_o.name_offset = off_d;
      result_o.name_length = len_d;
    end else if (phase_d == PhTag && cnt_d == '0) begin
      result_o.status = StatusAbsent;
    end else begin
      result_o.status = StatusMalformed;
    end

    // re-arm for the next message
    if (item_i.last) begin
      phase_d = PhTag;
      acc_d   = '0;
      cnt_d   = '0;
      skip_d  = '0;
      pos_d   = '0;
      off_d   = '0;
      len_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag;
      acc_q   <= '0;
      cnt_q   <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      off_q   <= '0;
      len_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      off_q   <= off_d;
      len_q   <= len_d;
    end
  end

endmodule

>>> hdl/protobuf_field_locator.sv
// top level of the protobuf field locator: channels, staging and result register
// usage
//   in channel: one message byte per transaction, last marks the final byte
//   out channel: one result transaction per message, issued for its last byte,
//     status found / not present / malformed with payload offset and length
//   cfg channel: writes the target field number, always ready, write only
//     while no message is in flight
// timing
//   a byte waits in the input register until it moves on and updates the
//   parser state; the result of a last byte is captured in the result register
//   as that byte moves on, and the result register drives out_valid_o
//   one byte per cycle sustained, including back-to-back messages, but for stalls
// stalls
//   a held result blocks only a following last byte; ordinary bytes keep
//   flowing until that last byte sits in the input register, then in_ready_o
//   stays low until the held result is taken
// reset
//   parser returns to reading a tag at offset zero, both registers empty,
//   target field number back to 1
`timescale 1ns / 1ps
module protobuf_field_locator #(
  parameter int unsigned MaxMessageBytes = pbfl_pkg::MaxMessageBytesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pbfl_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pbfl_pkg::out_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pbfl_pkg::TargetWidth-1:0] cfg_data_i
);
  import pbfl_pkg::*;
  `include "protobuf_field_locator_defines.svh"

  // input register
  logic      in_vld_q;
  in_item_t  in_q;
  // result register
  logic      out_vld_q;
  out_item_t out_q;
  // target field number
  logic [TargetWidth-1:0] target_q;

  out_item_t scan_res;
  logic      stage_adv;
  logic      in_acc;

  // the staged byte moves on unless it would produce a result with nowhere to go
  assign stage_adv  = in_vld_q && (!in_q.last || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || stage_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  pbfl_scan #(
    .MaxMessageBytes(MaxMessageBytes)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (stage_adv),
    .item_i  (in_q),
    .target_i(target_q),
    .result_o(scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      target_q  <= TargetReset;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (stage_adv) begin
        in_vld_q <= 1'b0;
      end
      if (stage_adv && in_q.last) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        target_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (stage_adv && in_q.last) begin
      out_q <= scan_res;
    end
  end

  // a last byte always lands a result
  `PBFL_ASSERT_NXT(a_last_gives_result, stage_adv && in_q.last, out_vld_q)
  // ordinary bytes never create or drop a result
  `PBFL_ASSERT_NXT(a_no_spurious_result, stage_adv && !in_q.last,
                   out_vld_q == $past(out_vld_q && !out_ready_i))
  // a staged byte is never lost while blocked
  `PBFL_ASSERT_NXT(a_stage_holds, in_vld_q && !stage_adv, in_vld_q)
  // status is one of the three defined codes
  `PBFL_ASSERT_IMP(a_status_legal, out_vld_q,
                   out_q.status == StatusFound || out_q.status == StatusAbsent ||
                   out_q.status == StatusMalformed)
  // offset and length only accompany a found status
  `PBFL_ASSERT_IMP(a_zero_unless_found, out_vld_q && out_q.status != StatusFound,
                   out_q.name_offset == '0 && out_q.name_length == '0)

endmodule
